[hdl/s3xaa_pkg.sv]
// Shared types and constants for the Scale3X edge anti-alias filter.
// Depends on nothing; the kernel and the top level refer to it by scoped names.
`default_nettype none

package s3xaa_pkg;

	// Pixel and geometry widths.
	localparam int PIX_BITS    = 16;
	localparam int MAX_WIDTH   = 2048;
	localparam int COL_BITS    = 11;
	localparam int ROW_BITS    = 12;
	localparam int WIDTH_BITS  = 12;
	localparam int HEIGHT_BITS = 13;
	localparam int CFG_BITS    = 16;
	localparam int IDX_BITS    = 2;

	// Weighted sub-pixel sum: 38 * (2^16 - 1) fits in 22 bits.
	localparam int SUM_BITS = 22;
	// 255 * sum + 19 * max fits in 30 bits.
	localparam int NUM_BITS = 30;

	// Configuration register indexes.
	localparam logic [IDX_BITS-1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [IDX_BITS-1:0] REG_FRAME_HEIGHT = 2'd1;
	localparam logic [IDX_BITS-1:0] REG_EQUAL_THRESH = 2'd2;

	// Reset values and clamp limits of the configuration.
	localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = 12'd640;
	localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = 13'd480;
	localparam logic [CFG_BITS-1:0]    THRESH_RESET = 16'd66;
	localparam logic [WIDTH_BITS-1:0]  WIDTH_MIN    = 12'd3;
	localparam logic [WIDTH_BITS-1:0]  WIDTH_MAX    = 12'd2048;
	localparam logic [HEIGHT_BITS-1:0] HEIGHT_MIN   = 13'd3;
	localparam logic [HEIGHT_BITS-1:0] HEIGHT_MAX   = 13'd4096;

	// Rounding division by 38 * max done as a multiply by a rounded-up reciprocal.
	// With a 52-bit shift the result is exact for every numerator below 2^30.
	localparam longint unsigned PIX_MAX     = 64'd65535;
	localparam longint unsigned DIV_CONST   = 64'd38 * PIX_MAX;
	localparam int              RECIP_SHIFT = 52;
	localparam logic [30:0]     RECIP       =
		31'(((64'd1 << RECIP_SHIFT) + DIV_CONST - 64'd1) / DIV_CONST);
	localparam logic [NUM_BITS-1:0] FRAC_BIAS = NUM_BITS'(64'd19 * PIX_MAX);
	localparam int PROD_BITS = NUM_BITS + 31;

	typedef logic [PIX_BITS-1:0] pix_t;

	// 3x3 neighborhood in raster order: a b c / d e f / g h i -> [0]..[8].
	typedef pix_t [8:0] nbhd_t;

	// What the kernel hands back for one neighborhood.
	typedef struct packed {
		logic                use_smooth;
		logic [SUM_BITS-1:0] sum;
	} kernel_res_t;

endpackage

`default_nettype wire

[hdl/scale3x_edge_antialias_filter_unit.sv]
// Path: a request's first result reaches the output via the stage 1, 2 and 3 registers.
// Throughput: one request per cycle while each causes at most one result and no out_stall.
// A request with k results holds the output register until all k are taken, which can stall
// the input; the first row and first column give none, a row end two, last-row pixels two
// or three (first column one). Reset clears positions and pipeline valids and loads 640 /
// 480 / 66; the line store and the window are not cleared.
`default_nettype none

module scale3x_edge_antialias_filter_unit (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  cfg_write,
	input  wire [s3xaa_pkg::IDX_BITS-1:0]        cfg_index,
	input  wire [s3xaa_pkg::CFG_BITS-1:0]        cfg_data,
	input  wire                                  in_valid,
	output logic                                 in_stall,
	input  wire [s3xaa_pkg::PIX_BITS-1:0]        pixel_value,
	output logic                                 out_valid,
	input  wire                                  out_stall,
	output logic [s3xaa_pkg::PIX_BITS-1:0]       out_value,
	output logic [s3xaa_pkg::COL_BITS-1:0]       out_column,
	output logic [s3xaa_pkg::ROW_BITS-1:0]       out_row,
	output logic                                 last_of_run
);

	// Configuration; width and height are stored already clamped.
	logic [s3xaa_pkg::WIDTH_BITS-1:0]  width_q;
	logic [s3xaa_pkg::HEIGHT_BITS-1:0] height_q;
	s3xaa_pkg::pix_t                   thresh_q;

	// Position of the next request.
	logic [s3xaa_pkg::COL_BITS-1:0] col_q;
	logic [s3xaa_pkg::ROW_BITS-1:0] row_q;

	// Pipeline control.
	logic v_s1, v_s2;
	logic [2:0] mask_s3;
	logic acc, adv1, adv2, s1_open, s2_open, s3_open, out_take;

	// Stage 1: pixel, position, line store read data.
	s3xaa_pkg::pix_t                pix_s1;
	logic [s3xaa_pkg::COL_BITS-1:0] c_s1;
	logic [s3xaa_pkg::ROW_BITS-1:0] r_s1;
	logic                           border_s1;
	logic [2:0]                     mask_s1;
	logic [2*s3xaa_pkg::PIX_BITS-1:0] mem_rd_s1;

	// Stage 2: kernel result.
	logic [s3xaa_pkg::SUM_BITS-1:0] sum_s2;
	logic                           smooth_s2;
	s3xaa_pkg::pix_t                ctr_s2, mid_s2, pix_s2;
	logic [s3xaa_pkg::COL_BITS-1:0] c_s2;
	logic [s3xaa_pkg::ROW_BITS-1:0] r_s2;
	logic [2:0]                     mask_s2;

	// Stage 3: result bundle.
	s3xaa_pkg::pix_t                val0_s3, mid_s3, pix_s3;
	logic [s3xaa_pkg::COL_BITS-1:0] c_s3;
	logic [s3xaa_pkg::ROW_BITS-1:0] r_s3;

	// Line store: upper half is the row two above, lower half the row above.
	logic [2*s3xaa_pkg::PIX_BITS-1:0] lb_mem [s3xaa_pkg::MAX_WIDTH];

	// Window columns: left and center column taps of the 3x3 neighborhood.
	s3xaa_pkg::pix_t win_q [6];

	// Clamp incoming configuration values.
	logic [s3xaa_pkg::WIDTH_BITS-1:0]  width_in;
	logic [s3xaa_pkg::HEIGHT_BITS-1:0] height_in;

	always_comb begin
		width_in  = cfg_data[s3xaa_pkg::WIDTH_BITS-1:0];
		height_in = cfg_data[s3xaa_pkg::HEIGHT_BITS-1:0];
		if (width_in < s3xaa_pkg::WIDTH_MIN)
			width_in = s3xaa_pkg::WIDTH_MIN;
		else if (width_in > s3xaa_pkg::WIDTH_MAX)
			width_in = s3xaa_pkg::WIDTH_MAX;
		if (height_in < s3xaa_pkg::HEIGHT_MIN)
			height_in = s3xaa_pkg::HEIGHT_MIN;
		else if (height_in > s3xaa_pkg::HEIGHT_MAX)
			height_in = s3xaa_pkg::HEIGHT_MAX;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= s3xaa_pkg::WIDTH_RESET;
			height_q <= s3xaa_pkg::HEIGHT_RESET;
			thresh_q <= s3xaa_pkg::THRESH_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				s3xaa_pkg::REG_FRAME_WIDTH:  width_q  <= width_in;
				s3xaa_pkg::REG_FRAME_HEIGHT: height_q <= height_in;
				s3xaa_pkg::REG_EQUAL_THRESH: thresh_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Handshake and stage advance chain.
	always_comb begin
		out_take = out_valid && !out_stall;
		s3_open  = (mask_s3 == 3'b000) || (out_take && ((mask_s3 & (mask_s3 - 3'd1)) == 3'b000));
		adv2     = v_s2 && s3_open;
		s2_open  = !v_s2 || s3_open;
		adv1     = v_s1 && s2_open;
		s1_open  = !v_s1 || s2_open;
		in_stall = !s1_open;
		acc      = in_valid && s1_open;
	end

	// Position of the accepted pixel, with wrap if the frame size shrank while idle.
	logic [s3xaa_pkg::COL_BITS-1:0]    c_now;
	logic [s3xaa_pkg::ROW_BITS-1:0]    r_now;
	logic [s3xaa_pkg::HEIGHT_BITS-1:0] r_pre, r_inc;
	logic [s3xaa_pkg::WIDTH_BITS-1:0]  c_inc;
	logic [s3xaa_pkg::COL_BITS-1:0]    col_next;
	logic [s3xaa_pkg::ROW_BITS-1:0]    row_upd;
	logic                              first_ok, col_last, row_last;

	always_comb begin
		if ({1'b0, col_q} >= width_q) begin
			c_now = '0;
			r_pre = s3xaa_pkg::HEIGHT_BITS'(row_q) + 13'd1;
		end else begin
			c_now = col_q;
			r_pre = s3xaa_pkg::HEIGHT_BITS'(row_q);
		end
		r_now = (r_pre >= height_q) ? '0 : r_pre[s3xaa_pkg::ROW_BITS-1:0];

		col_last = ({1'b0, c_now} == (width_q - 12'd1));
		row_last = ({1'b0, r_now} == (height_q - 13'd1));
		first_ok = (c_now != '0) && (r_now != '0);

		c_inc = s3xaa_pkg::WIDTH_BITS'(c_now) + 12'd1;
		r_inc = s3xaa_pkg::HEIGHT_BITS'(r_now) + 13'd1;
		if (c_inc >= width_q) begin
			col_next = '0;
			row_upd  = (r_inc >= height_q) ? '0 : r_inc[s3xaa_pkg::ROW_BITS-1:0];
		end else begin
			col_next = c_inc[s3xaa_pkg::COL_BITS-1:0];
			row_upd  = r_now;
		end
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			mask_s3 <= 3'b000;
		end else begin
			if (acc) begin
				col_q <= col_next;
				row_q <= row_upd;
			end
			if (s1_open)
				v_s1 <= acc;
			if (s2_open)
				v_s2 <= adv1;
			if (adv2)
				mask_s3 <= mask_s2;
			else if (out_take)
				mask_s3 <= mask_s3 & (mask_s3 - 3'd1);
		end
	end

	// Line store: read on accept, write back when the request leaves stage 1.
	always_ff @(posedge clk) begin
		if (acc)
			mem_rd_s1 <= lb_mem[c_now];
		if (adv1)
			lb_mem[c_s1] <= {mem_rd_s1[s3xaa_pkg::PIX_BITS-1:0], pix_s1};
	end

	// Stage 1 payload.
	always_ff @(posedge clk) begin
		if (acc) begin
			pix_s1    <= pixel_value;
			c_s1      <= c_now;
			r_s1      <= r_now;
			border_s1 <= (c_now == s3xaa_pkg::COL_BITS'(1)) || (r_now == s3xaa_pkg::ROW_BITS'(1));
			mask_s1   <= {row_last, first_ok && col_last, first_ok};
		end
	end

	// Neighborhood for the kernel.
	s3xaa_pkg::pix_t top_s1, mid_s1;
	s3xaa_pkg::nbhd_t nbhd;
	s3xaa_pkg::kernel_res_t kres;

	assign top_s1 = mem_rd_s1[2*s3xaa_pkg::PIX_BITS-1:s3xaa_pkg::PIX_BITS];
	assign mid_s1 = mem_rd_s1[s3xaa_pkg::PIX_BITS-1:0];

	always_comb begin
		nbhd[0] = win_q[0];
		nbhd[1] = win_q[3];
		nbhd[2] = top_s1;
		nbhd[3] = win_q[1];
		nbhd[4] = win_q[4];
		nbhd[5] = mid_s1;
		nbhd[6] = win_q[2];
		nbhd[7] = win_q[5];
		nbhd[8] = pix_s1;
	end

	s3xaa_kernel u_kernel (
		.nbhd      (nbhd),
		.threshold (thresh_q),
		.res       (kres)
	);

	// Window shift and stage 2 load.
	always_ff @(posedge clk) begin
		if (adv1) begin
			win_q[0]  <= win_q[3];
			win_q[1]  <= win_q[4];
			win_q[2]  <= win_q[5];
			win_q[3]  <= top_s1;
			win_q[4]  <= mid_s1;
			win_q[5]  <= pix_s1;
			sum_s2    <= kres.sum;
			smooth_s2 <= kres.use_smooth && !border_s1;
			ctr_s2    <= win_q[4];
			mid_s2    <= mid_s1;
			pix_s2    <= pix_s1;
			c_s2      <= c_s1;
			r_s2      <= r_s1;
			mask_s2   <= mask_s1;
		end
	end

	// Reduce the sum to 8 bits by the reciprocal multiply, then expand back.
	logic [s3xaa_pkg::NUM_BITS-1:0]  num_s2;
	logic [s3xaa_pkg::PROD_BITS-1:0] prod_s2;
	logic [7:0]                      q_s2;

	always_comb begin
		num_s2  = s3xaa_pkg::NUM_BITS'({sum_s2, 8'h00}) - s3xaa_pkg::NUM_BITS'(sum_s2)
			+ s3xaa_pkg::FRAC_BIAS;
		prod_s2 = s3xaa_pkg::PROD_BITS'(num_s2) * s3xaa_pkg::PROD_BITS'(s3xaa_pkg::RECIP);
		q_s2    = (prod_s2[s3xaa_pkg::PROD_BITS-1:s3xaa_pkg::RECIP_SHIFT+8] != '0) ? 8'hFF
			: prod_s2[s3xaa_pkg::RECIP_SHIFT+7:s3xaa_pkg::RECIP_SHIFT];
	end

	// Stage 3: result bundle held for the output port.
	always_ff @(posedge clk) begin
		if (adv2) begin
			val0_s3 <= smooth_s2 ? {q_s2, q_s2} : ctr_s2;
			mid_s3  <= mid_s2;
			pix_s3  <= pix_s2;
			c_s3    <= c_s2;
			r_s3    <= r_s2;
		end
	end

	// Present the earliest pending result of the bundle.
	always_comb begin
		out_valid   = (mask_s3 != 3'b000);
		last_of_run = ((mask_s3 & (mask_s3 - 3'd1)) == 3'b000);
		if (mask_s3[0]) begin
			out_value  = val0_s3;
			out_column = c_s3 - s3xaa_pkg::COL_BITS'(1);
			out_row    = r_s3 - s3xaa_pkg::ROW_BITS'(1);
		end else if (mask_s3[1]) begin
			out_value  = mid_s3;
			out_column = c_s3;
			out_row    = r_s3 - s3xaa_pkg::ROW_BITS'(1);
		end else begin
			out_value  = pix_s3;
			out_column = c_s3;
			out_row    = r_s3;
		end
	end

`ifndef NO_ASSERTIONS
	// A full stage 1 can only take a new request while it hands its own one on.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && v_s1) |-> adv1)
		else $error("request accepted into a stage 1 that is not advancing");

	// Line store read and write-back never hit the same column in one cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(acc && adv1) |-> (c_now != c_s1))
		else $error("line store read and write collide");

	// Taking the final result with nothing behind it empties the output.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_take && last_of_run && !adv2) |=> !out_valid)
		else $error("output still valid after its final result");

	// A bundle with results shows up at the output in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(adv2 && (mask_s2 != 3'b000)) |=> out_valid)
		else $error("result bundle lost on its way to the output");
`endif

endmodule

`default_nettype wire

[hdl/s3xaa_kernel.sv]
// Scale3X rule evaluation and weighted sub-pixel sum for one 3x3 neighborhood.
// Uses types and widths from s3xaa_pkg.
`default_nettype none

module s3xaa_kernel (
	input  wire s3xaa_pkg::nbhd_t       nbhd,
	input  wire s3xaa_pkg::pix_t        threshold,
	output s3xaa_pkg::kernel_res_t      res
);

	// Two pixels count as equal when their distance is below the threshold.
	function automatic logic near(input s3xaa_pkg::pix_t x, input s3xaa_pkg::pix_t y,
			input s3xaa_pkg::pix_t thr);
		s3xaa_pkg::pix_t diff;
		begin
			diff = (x > y) ? (x - y) : (y - x);
			return diff < thr;
		end
	endfunction

	s3xaa_pkg::pix_t pa, pb, pc, pd, pe, pf, pg, ph, pi;
	s3xaa_pkg::pix_t s0, s1, s2, s3, s5, s6, s7, s8;
	logic db, bf, dh, hf;
	logic ec, ea, eg, ei;
	logic [17:0] corner_sum, edge_sum;

	assign pa = nbhd[0];
	assign pb = nbhd[1];
	assign pc = nbhd[2];
	assign pd = nbhd[3];
	assign pe = nbhd[4];
	assign pf = nbhd[5];
	assign pg = nbhd[6];
	assign ph = nbhd[7];
	assign pi = nbhd[8];

	// Pairwise equality tests of the edge rules.
	assign db = near(pd, pb, threshold);
	assign bf = near(pb, pf, threshold);
	assign dh = near(pd, ph, threshold);
	assign hf = near(ph, pf, threshold);
	assign ea = near(pe, pa, threshold);
	assign ec = near(pe, pc, threshold);
	assign eg = near(pe, pg, threshold);
	assign ei = near(pe, pi, threshold);

	// Sub-pixel selection of the 3x expansion.
	always_comb begin
		s0 = db ? pd : pe;
		s1 = ((db && !ec) || (bf && !ea)) ? pb : pe;
		s2 = bf ? pf : pe;
		s3 = ((db && !eg) || (dh && !ea)) ? pd : pe;
		s5 = ((bf && !ei) || (hf && !ec)) ? pf : pe;
		s6 = dh ? pd : pe;
		s7 = ((dh && !ei) || (hf && !eg)) ? ph : pe;
		s8 = hf ? pf : pe;
	end

	// Weighted sum: corners by 3, edges by 5, center by 6.
	assign corner_sum = 18'(s0) + 18'(s2) + 18'(s6) + 18'(s8);
	assign edge_sum   = 18'(s1) + 18'(s3) + 18'(s5) + 18'(s7);

	always_comb begin
		res.use_smooth = !(near(pb, ph, threshold) || near(pd, pf, threshold));
		res.sum = s3xaa_pkg::SUM_BITS'({corner_sum, 1'b0}) + s3xaa_pkg::SUM_BITS'(corner_sum)
			+ s3xaa_pkg::SUM_BITS'({edge_sum, 2'b00}) + s3xaa_pkg::SUM_BITS'(edge_sum)
			+ s3xaa_pkg::SUM_BITS'({pe, 2'b00}) + s3xaa_pkg::SUM_BITS'({pe, 1'b0});
	end

endmodule

`default_nettype wire
